@@ rtl/link_traffic_rate_monitor_assert.svh @@
// Assertion macros used by the checker
`ifndef LINK_TRAFFIC_RATE_MONITOR_ASSERT_SVH
`define LINK_TRAFFIC_RATE_MONITOR_ASSERT_SVH

// same-cycle implication
`define LTRM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LTRM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ltrm_pkg.sv @@
`default_nettype none
package ltrm_pkg;

    localparam logic [2:0] ACT_AUX_SENT  = 3'd0;
    localparam logic [2:0] ACT_AUX_RCV   = 3'd1;
    localparam logic [2:0] ACT_LINK_SENT = 3'd2;
    localparam logic [2:0] ACT_LINK_RCV  = 3'd3;
    localparam logic [2:0] ACT_FAILURE   = 3'd4;
    localparam logic [2:0] ACT_TICK      = 3'd5;
    localparam logic [2:0] ACT_CLEAR     = 3'd6;
    localparam logic [2:0] ACT_READ      = 3'd7;

    localparam logic [3:0] STAT_FIRST_RATE = 4'd5;
    localparam logic [3:0] STAT_RATIO      = 4'd11;

    localparam logic CFG_EMA_WEIGHT = 1'b0;
    localparam logic CFG_TPS        = 1'b1;

    localparam logic [15:0] EMA_WEIGHT_RESET = 16'd3277;
    localparam logic [9:0]  TPS_RESET        = 10'd10;

    localparam int OUT_W = 48;
    localparam int NUM_RATES = 6;
    localparam int NUM_COUNTS = 5;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] byte_count;
        logic [3:0]  stat_index;
        logic        is_event;
        logic        is_tick;
    } item_t;

endpackage
`default_nettype wire

@@ rtl/ltrm_front.sv @@
`default_nettype none
module ltrm_front
    import ltrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] byte_count,
    input  wire logic [3:0]  stat_index,
    output logic             q_valid,
    input  wire logic        q_pop,
    output item_t            q_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    item_t       item_in;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        item_in.action     = action;
        item_in.byte_count = byte_count;
        item_in.stat_index = stat_index;
        item_in.is_event   = (action <= ACT_FAILURE);
        item_in.is_tick    = (action == ACT_TICK);
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ltrm_div.sv @@
`default_nettype none
module ltrm_div
    import ltrm_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [COUNT_BITS-1:0] num,
    input  wire logic [COUNT_BITS:0]   den,
    output logic                       done,
    output logic [16:0]                quo
);

    logic [COUNT_BITS+1:0] rem_reg, rem_next;
    logic [16:0]           quo_reg, quo_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COUNT_BITS+1:0] rem_sh;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb
    begin
        rem_sh    = {rem_reg[COUNT_BITS:0], 1'b0};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            if ({1'b0, num} >= den)
            begin
                quo_next  = 17'h10000;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {2'b00, num};
                quo_next  = '0;
                cnt_next  = 5'd16;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (rem_sh >= {1'b0, den})
            begin
                rem_next = rem_sh - {1'b0, den};
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ltrm_back.sv @@
`default_nettype none
module ltrm_back
    import ltrm_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int RATE_FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire item_t       q_item,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [47:0]      read_value,
    output logic             modified
);

    localparam int RATE_W = 32 + RATE_FRAC_BITS;
    localparam int NCH    = (RATE_W + 15) / 16;
    localparam int PAD_W  = NCH * 16;
    localparam int ACC_W  = PAD_W + 18;
    localparam int PW     = COUNT_BITS + 10;
    localparam int CW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int WIDE   = RATE_W + COUNT_BITS + OUT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PROD = 3'd1;
    localparam logic [2:0] S_MIX  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RMIX = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            e_reg, e_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [15:0]           weight_reg;
    logic [9:0]            tps_reg;
    logic [COUNT_BITS-1:0] total_reg [NUM_COUNTS];
    logic [COUNT_BITS-1:0] period_reg [NUM_COUNTS];
    logic [COUNT_BITS-1:0] bytes_reg [2];
    logic [RATE_W-1:0]     rate_reg [NUM_RATES];
    logic [16:0]           ratio_reg;
    logic                  mod_reg;
    logic                  ov_reg;
    logic [47:0]           rv_reg;
    logic [PW-1:0]         prod_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;

    logic                  slot_free;
    logic                  pop;
    logic [16:0]           wk;
    logic [9:0]            tps_eff;
    logic [2:0]            ridx;
    logic [RATE_W-1:0]     rate_rd;
    logic [COUNT_BITS-1:0] cnt_sel;
    logic [RATE_W-1:0]     smp;
    logic [PAD_W-1:0]      old_pad, smp_pad;
    logic [15:0]           oc, sc;
    logic [33:0]           term;
    logic [ACC_W-1:0]      rounded;
    logic [COUNT_BITS:0]   nlink;
    logic                  div_start, div_done;
    logic [16:0]           div_q;
    logic [34:0]           rmix;
    logic [WIDE-1:0]       stat_wide;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [15:0]           b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS+1)'(b);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    assign slot_free  = !ov_reg || out_ready;
    assign pop        = (state_reg == S_IDLE) && q_valid && slot_free;
    assign q_pop      = pop;
    assign out_valid  = ov_reg;
    assign read_value = rv_reg;
    assign modified   = mod_reg;
    assign wk         = 17'h10000 - {1'b0, weight_reg};
    assign tps_eff    = (tps_reg == 10'd0) ? 10'd1 : tps_reg;
    assign nlink      = {1'b0, period_reg[ACT_LINK_SENT]} + {1'b0, period_reg[ACT_LINK_RCV]};

    // share one read port between the statistic read and the tick sweep
    always_comb
    begin
        ridx = (state_reg == S_IDLE) ? 3'(q_item.stat_index - STAT_FIRST_RATE) : e_reg;
        rate_rd = (ridx < 3'(NUM_RATES)) ? rate_reg[ridx] : '0;
    end

    always_comb
    begin
        unique case (e_reg)
            3'd0:    cnt_sel = bytes_reg[0];
            3'd1:    cnt_sel = bytes_reg[1];
            3'd2:    cnt_sel = period_reg[ACT_AUX_SENT];
            3'd3:    cnt_sel = period_reg[ACT_AUX_RCV];
            3'd4:    cnt_sel = period_reg[ACT_LINK_SENT];
            default: cnt_sel = period_reg[ACT_LINK_RCV];
        endcase
    end

    always_comb
    begin
        if ((PW+32)'(prod_reg) > (PW+32)'(33'h0_FFFF_FFFF))
        begin
            smp = '1;
        end
        else
        begin
            smp = RATE_W'((PW+32)'(prod_reg) << RATE_FRAC_BITS);
        end
        old_pad  = PAD_W'(rate_rd);
        smp_pad  = PAD_W'(smp);
        oc       = old_pad[16*k_reg +: 16];
        sc       = smp_pad[16*k_reg +: 16];
        term     = 34'(oc * wk) + 34'(sc * weight_reg);
        acc_next = (acc_reg << 16) + ACC_W'(term);
        rounded  = (acc_next + ACC_W'(32'h8000)) >> 16;
        rmix     = 35'(ratio_reg * wk) + 35'(div_q * weight_reg) + 35'(32'h8000);
    end

    always_comb
    begin
        priority if (q_item.stat_index < STAT_FIRST_RATE)
        begin
            stat_wide = WIDE'(total_reg[3'(q_item.stat_index)]);
        end
        else if (q_item.stat_index < STAT_RATIO)
        begin
            stat_wide = WIDE'(rate_rd);
        end
        else if (q_item.stat_index == STAT_RATIO)
        begin
            stat_wide = WIDE'(ratio_reg);
        end
        else
        begin
            stat_wide = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && q_item.is_tick)
                begin
                    state_next = S_PROD;
                    e_next     = 3'd0;
                end
            end
            S_PROD:
            begin
                state_next = S_MIX;
                k_next     = CW'(NCH - 1);
            end
            S_MIX:
            begin
                k_next = k_reg - CW'(1);
                if (k_reg == CW'(0))
                begin
                    if (e_reg == 3'(NUM_RATES - 1))
                    begin
                        if (nlink != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        e_next     = e_reg + 3'd1;
                        state_next = S_PROD;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RMIX;
                end
            end
            S_RMIX:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ltrm_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (period_reg[ACT_FAILURE]),
        .den   (nlink),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PROD)
        begin
            prod_reg <= PW'(cnt_sel * tps_eff);
            acc_reg  <= '0;
        end
        else if (state_reg == S_MIX)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            e_reg      <= 3'd0;
            k_reg      <= '0;
            weight_reg <= EMA_WEIGHT_RESET;
            tps_reg    <= TPS_RESET;
            for (int i = 0; i < NUM_COUNTS; i++)
            begin
                total_reg[i]  <= '0;
                period_reg[i] <= '0;
            end
            bytes_reg[0] <= '0;
            bytes_reg[1] <= '0;
            for (int i = 0; i < NUM_RATES; i++)
            begin
                rate_reg[i] <= '0;
            end
            ratio_reg <= '0;
            mod_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            rv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            k_reg     <= k_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_EMA_WEIGHT: weight_reg <= cfg_data;
                    CFG_TPS:        tps_reg    <= cfg_data[9:0];
                    default:        weight_reg <= weight_reg;
                endcase
            end
            if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (pop && !q_item.is_tick)
            begin
                ov_reg <= 1'b1;
                rv_reg <= '0;
                if (q_item.is_event)
                begin
                    for (int i = 0; i < NUM_COUNTS; i++)
                    begin
                        if (q_item.action == 3'(i))
                        begin
                            total_reg[i]  <= sat_add(total_reg[i], 16'd1);
                            period_reg[i] <= sat_add(period_reg[i], 16'd1);
                        end
                    end
                    if (q_item.action == ACT_LINK_SENT)
                    begin
                        bytes_reg[0] <= sat_add(bytes_reg[0], q_item.byte_count);
                    end
                    if (q_item.action == ACT_LINK_RCV)
                    begin
                        bytes_reg[1] <= sat_add(bytes_reg[1], q_item.byte_count);
                    end
                    mod_reg <= 1'b1;
                end
                else if (q_item.action == ACT_CLEAR)
                begin
                    mod_reg <= 1'b0;
                end
                else
                begin
                    rv_reg <= stat_wide[47:0];
                end
            end
            if (state_reg == S_MIX && k_reg == CW'(0))
            begin
                rate_reg[e_reg] <= rounded[RATE_W-1:0];
            end
            if (state_reg == S_RMIX)
            begin
                ratio_reg <= rmix[32:16];
            end
            if (state_reg == S_DONE && slot_free)
            begin
                // close the period and post a zero result beat
                for (int i = 0; i < NUM_COUNTS; i++)
                begin
                    period_reg[i] <= '0;
                end
                bytes_reg[0] <= '0;
                bytes_reg[1] <= '0;
                ov_reg <= 1'b1;
                rv_reg <= '0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/link_traffic_rate_monitor.sv @@
// An event, clear or read beat passes through the two-entry input queue, and its result is then
// registered in the output register. The back end takes one non-tick beat per cycle while the
// output slot is free and no tick is in progress. A tick holds the back end: for each of 6 rates,
// a product step and mix steps over 16-bit slices on one multiplier pair; then, if link messages
// came in the period, the divide (saturating when failures reach them), a ratio and a closing step.
// Reset (rst_n low, asynchronous) clears all counters, averages and flags at once.
`default_nettype none
module link_traffic_rate_monitor
    import ltrm_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int RATE_FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] byte_count,
    input  wire logic [3:0]  stat_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [47:0]      read_value,
    output logic             modified,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    ltrm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .byte_count (byte_count),
        .stat_index (stat_index),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    ltrm_back #(
        .COUNT_BITS     (COUNT_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .modified   (modified)
    );

endmodule
`default_nettype wire

@@ rtl/ltrm_checker.sv @@
`default_nettype none
`include "link_traffic_rate_monitor_assert.svh"
module ltrm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [47:0] read_value,
    input wire logic        modified,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // hold a stalled result beat
    `LTRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(modified))
    `LTRM_ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)
    // no result and no modified flag as reset is released
    `LTRM_ASSERT_IMPL(a_reset_idle, clk, rst_n, $rose(rst_n), !out_valid && !modified)

endmodule

bind link_traffic_rate_monitor ltrm_checker u_chk (.*);
`default_nettype wire
